/* rtl/mbrm_pkg.sv */
// Shared types, constants and the CRC-16/MODBUS byte step of the Modbus RTU read master.
// No dependencies; compiled first.
package mbrm_pkg;

   localparam int MAX_REGISTERS = 8;
   // registers per response, bounded by the 3-bit register index
   localparam int CAP_REGS      = (MAX_REGISTERS < 8) ? MAX_REGISTERS : 8;
   localparam int REG_IDX_W     = 3;
   localparam int FMEM_DEPTH    = 2 ** REG_IDX_W;
   localparam int CSR_IDX_W     = 3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // response framing: address, function, byte count, data, two CRC bytes
   localparam logic [4:0] RSP_HDR_BYTES  = 5'd3;
   localparam logic [4:0] RSP_OVERHEAD   = 5'd5;

   typedef enum logic [1:0] {
      FUNC_START = 2'd0,
      FUNC_RX    = 2'd1,
      FUNC_TICK  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_TX      = 2'd0,
      KIND_REG     = 2'd1,
      KIND_CRC_ERR = 2'd2,
      KIND_TIMEOUT = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_ADDR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FUNC_CODE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_REG  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT    = 3'd4;

   // request byte positions
   localparam logic [2:0] TXB_ADDR     = 3'd0;
   localparam logic [2:0] TXB_FUNC     = 3'd1;
   localparam logic [2:0] TXB_START_HI = 3'd2;
   localparam logic [2:0] TXB_START_LO = 3'd3;
   localparam logic [2:0] TXB_COUNT_HI = 3'd4;
   localparam logic [2:0] TXB_COUNT_LO = 3'd5;
   localparam logic [2:0] TXB_CRC_LO   = 3'd6;
   localparam logic [2:0] TXB_CRC_HI   = 3'd7;

   typedef struct packed {
      logic                 en;
      logic                 bank;   // 0: high byte of a register, 1: low byte
      logic [REG_IDX_W-1:0] addr;
      logic [7:0]           data;
   } fmem_wr_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/mbrm_if.sv */
// Valid/ready channel interfaces: request items, result items and register writes.
// Depends on mbrm_pkg.
interface mbrm_req_if;
   import mbrm_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] rx_byte;
   modport source (output valid, func, rx_byte, input ready);
   modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface mbrm_rsp_if;
   import mbrm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [7:0]           tx_byte;
   logic [REG_IDX_W-1:0] register_index;
   logic [15:0]          register_value;
   logic                 last;
   modport source (output valid, kind, tx_byte, register_index, register_value, last,
                   input ready);
   modport sink   (input valid, kind, tx_byte, register_index, register_value, last,
                   output ready);
endinterface

interface mbrm_csr_if;
   import mbrm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [15:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/mbrm_frame_store.sv */
// Register data store of the response frame: two byte banks, one write, one registered read.
// Depends on mbrm_pkg.
module mbrm_frame_store (
   input  logic                          clock,
   input  mbrm_pkg::fmem_wr_type         wr,
   input  logic [mbrm_pkg::REG_IDX_W-1:0] rd_addr,
   output logic [15:0]                   rd_value
);
   import mbrm_pkg::*;

   logic [7:0] hi_mem [FMEM_DEPTH];
   logic [7:0] lo_mem [FMEM_DEPTH];
   logic [7:0] rd_hi_ff;
   logic [7:0] rd_lo_ff;

   always_ff @(posedge clock) begin
      if (wr.en && !wr.bank) begin
         hi_mem[wr.addr] <= wr.data;
      end
      if (wr.en && wr.bank) begin
         lo_mem[wr.addr] <= wr.data;
      end
      rd_hi_ff <= hi_mem[rd_addr];
      rd_lo_ff <= lo_mem[rd_addr];
   end

   assign rd_value = {rd_hi_ff, rd_lo_ff};

endmodule

/* rtl/modbus_rtu_register_read_master_core.sv */
// Top level of the Modbus RTU read-holding-registers master.
// Depends on mbrm_pkg, mbrm_if.sv and mbrm_frame_store.
//
// A received byte, a tick or an ignored code is taken in idle when the result register is free;
// a start emits its eight request bytes, folding the six header bytes into the CRC register one
// byte a cycle while the result register is free. A good frame end emits its registers in turn,
// each via ST_RD (registered frame store read), then ST_REG; a CRC error or timeout is a single
// result, loaded as the item is taken. Input is held off while a request or register burst goes
// out. The frame store has no reset: every data byte is written before the frame can complete.
module modbus_rtu_register_read_master_core (
   input  logic        clock,
   input  logic        reset,
   mbrm_req_if.sink    req_ch,
   mbrm_rsp_if.source  rsp_ch,
   mbrm_csr_if.sink    csr_ch
);
   import mbrm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_TX   = 4'b0010,
      ST_RD   = 4'b0100,
      ST_REG  = 4'b1000
   } state_type;

   localparam logic [3:0] CAP_N = 4'(CAP_REGS);

   // configuration
   logic [7:0]  slave_addr_ff;
   logic [7:0]  func_code_ff;
   logic [15:0] first_reg_ff;
   logic [3:0]  reg_count_ff;
   logic [15:0] timeout_ff;

   // transaction state
   state_type      state_ff, state_in;
   logic           waiting_ff, waiting_in;
   logic [4:0]     rcv_cnt_ff, rcv_cnt_in;
   logic [15:0]    crc_ff, crc_in;
   logic [15:0]    elapsed_ff, elapsed_in;
   logic [3:0]     active_cnt_ff, active_cnt_in;
   logic [REG_IDX_W-1:0] seq_ff, seq_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff, out_kind;
   logic [7:0]           rsp_tx_ff, out_tx;
   logic [REG_IDX_W-1:0] rsp_idx_ff, out_idx;
   logic [15:0]          rsp_val_ff, out_val;
   logic                 rsp_last_ff, out_last;
   logic                 load_out;

   logic        out_free;
   logic        req_fire;
   logic [3:0]  n_sat;
   logic [4:0]  total_len;
   logic [4:0]  data_end;
   logic [4:0]  data_pos;
   logic [4:0]  rcv_next;
   logic [7:0]  tx_sel;
   logic [7:0]  crc_src;
   logic [15:0] crc_fold;
   logic [15:0] rd_value;
   logic        reg_last;
   fmem_wr_type fmem_wr;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign n_sat     = (reg_count_ff == 4'd0) ? 4'd1 :
                      (reg_count_ff > CAP_N) ? CAP_N : reg_count_ff;
   assign total_len = RSP_OVERHEAD + {active_cnt_ff, 1'b0};
   assign data_end  = RSP_HDR_BYTES + {active_cnt_ff, 1'b0};
   assign data_pos  = rcv_cnt_ff - RSP_HDR_BYTES;
   assign rcv_next  = rcv_cnt_ff + 5'd1;
   assign reg_last  = ({1'b0, seq_ff} + 4'd1) == active_cnt_ff;

   always_comb begin
      unique case (seq_ff)
         TXB_ADDR:     tx_sel = slave_addr_ff;
         TXB_FUNC:     tx_sel = func_code_ff;
         TXB_START_HI: tx_sel = first_reg_ff[15:8];
         TXB_START_LO: tx_sel = first_reg_ff[7:0];
         TXB_COUNT_HI: tx_sel = 8'h00;
         TXB_COUNT_LO: tx_sel = {4'h0, active_cnt_ff};
         TXB_CRC_LO:   tx_sel = crc_ff[7:0];
         TXB_CRC_HI:   tx_sel = crc_ff[15:8];
         default:      tx_sel = 8'h00;
      endcase
   end

   // one CRC step shared by request bytes and received bytes
   assign crc_src  = (state_ff == ST_TX) ? tx_sel : req_ch.rx_byte;
   assign crc_fold = crc_byte(crc_ff, crc_src);

   always_comb begin
      state_in      = state_ff;
      waiting_in    = waiting_ff;
      rcv_cnt_in    = rcv_cnt_ff;
      crc_in        = crc_ff;
      elapsed_in    = elapsed_ff;
      active_cnt_in = active_cnt_ff;
      seq_in        = seq_ff;
      load_out      = 1'b0;
      out_kind      = KIND_TX;
      out_tx        = 8'h00;
      out_idx       = '0;
      out_val       = 16'h0000;
      out_last      = 1'b0;
      fmem_wr.en    = 1'b0;
      fmem_wr.bank  = data_pos[0];
      fmem_wr.addr  = data_pos[REG_IDX_W:1];
      fmem_wr.data  = req_ch.rx_byte;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.func)
                  FUNC_START: begin
                     active_cnt_in = n_sat;
                     waiting_in    = 1'b1;
                     rcv_cnt_in    = 5'd0;
                     crc_in        = CRC_INIT;
                     elapsed_in    = 16'h0000;
                     seq_in        = TXB_ADDR;
                     state_in      = ST_TX;
                  end
                  FUNC_RX: begin
                     if (waiting_ff) begin
                        crc_in     = crc_fold;
                        rcv_cnt_in = rcv_next;
                        fmem_wr.en = (rcv_cnt_ff >= RSP_HDR_BYTES) && (rcv_cnt_ff < data_end);
                        if (rcv_next == total_len) begin
                           waiting_in = 1'b0;
                           if (crc_fold != 16'h0000) begin
                              load_out = 1'b1;
                              out_kind = KIND_CRC_ERR;
                              out_last = 1'b1;
                           end else begin
                              seq_in   = '0;
                              state_in = ST_RD;
                           end
                        end
                     end
                  end
                  FUNC_TICK: begin
                     if (waiting_ff) begin
                        if (elapsed_ff >= timeout_ff) begin
                           waiting_in = 1'b0;
                           load_out   = 1'b1;
                           out_kind   = KIND_TIMEOUT;
                           out_last   = 1'b1;
                        end else begin
                           elapsed_in = elapsed_ff + 16'd1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_TX: begin
            if (out_free) begin
               load_out = 1'b1;
               out_kind = KIND_TX;
               out_tx   = tx_sel;
               out_last = (seq_ff == TXB_CRC_HI);
               if (seq_ff == TXB_CRC_HI) begin
                  crc_in   = CRC_INIT;
                  state_in = ST_IDLE;
               end else begin
                  if (seq_ff < TXB_CRC_LO) begin
                     crc_in = crc_fold;
                  end
                  seq_in = seq_ff + 3'd1;
               end
            end
         end
         ST_RD: begin
            state_in = ST_REG;
         end
         ST_REG: begin
            if (out_free) begin
               load_out = 1'b1;
               out_kind = KIND_REG;
               out_idx  = seq_ff;
               out_val  = rd_value;
               out_last = reg_last;
               if (reg_last) begin
                  state_in = ST_IDLE;
               end else begin
                  seq_in   = seq_ff + 3'd1;
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = load_out ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         waiting_ff    <= 1'b0;
         rcv_cnt_ff    <= 5'd0;
         crc_ff        <= CRC_INIT;
         elapsed_ff    <= 16'h0000;
         active_cnt_ff <= 4'd1;
         seq_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         waiting_ff    <= waiting_in;
         rcv_cnt_ff    <= rcv_cnt_in;
         crc_ff        <= crc_in;
         elapsed_ff    <= elapsed_in;
         active_cnt_ff <= active_cnt_in;
         seq_ff        <= seq_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_kind_ff <= out_kind;
         rsp_tx_ff   <= out_tx;
         rsp_idx_ff  <= out_idx;
         rsp_val_ff  <= out_val;
         rsp_last_ff <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= 8'd1;
         func_code_ff  <= 8'd3;
         first_reg_ff  <= 16'd0;
         reg_count_ff  <= 4'd7;
         timeout_ff    <= 16'd500;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_SLAVE_ADDR: slave_addr_ff <= csr_ch.data[7:0];
            CSR_FUNC_CODE:  func_code_ff  <= csr_ch.data[7:0];
            CSR_FIRST_REG:  first_reg_ff  <= csr_ch.data;
            CSR_REG_COUNT:  reg_count_ff  <= csr_ch.data[3:0];
            CSR_TIMEOUT:    timeout_ff    <= csr_ch.data;
            default: ;
         endcase
      end
   end

   mbrm_frame_store u_frame_store (
      .clock    (clock),
      .wr       (fmem_wr),
      .rd_addr  (seq_ff),
      .rd_value (rd_value)
   );

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.kind           = rsp_kind_ff;
   assign rsp_ch.tx_byte        = rsp_tx_ff;
   assign rsp_ch.register_index = rsp_idx_ff;
   assign rsp_ch.register_value = rsp_val_ff;
   assign rsp_ch.last           = rsp_last_ff;

   a_start_enters_tx: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_ch.func == FUNC_START) |=> (state_ff == ST_TX) && waiting_ff)
      else $error("start item did not launch the request");

   a_count_in_frame: assert property (@(posedge clock) disable iff (reset)
      waiting_ff |-> (rcv_cnt_ff < total_len))
      else $error("received count ran past the frame length");

   a_burst_not_waiting: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD || state_ff == ST_REG) |-> !waiting_ff)
      else $error("register burst while still waiting for bytes");

   a_active_range: assert property (@(posedge clock) disable iff (reset)
      (active_cnt_ff >= 4'd1) && (active_cnt_ff <= CAP_N))
      else $error("latched register count out of range");

endmodule
